[rtl/sdcs_pkg.sv]
package sdcs_pkg;

    // Drive state codes reported in the result.
    localparam logic [2:0] ST_OFF     = 3'd0;
    localparam logic [2:0] ST_STOPPED = 3'd1;
    localparam logic [2:0] ST_ENABLED = 3'd2;
    localparam logic [2:0] ST_RUNNING = 3'd3;
    localparam logic [2:0] ST_FAULT   = 3'd4;

    // Requested drive states.
    localparam logic [1:0] REQ_OFF    = 2'd0;
    localparam logic [1:0] REQ_STOP   = 2'd1;
    localparam logic [1:0] REQ_ENABLE = 2'd2;
    localparam logic [1:0] REQ_RUN    = 2'd3;

    // Operation modes as the application encodes them; OM_NONE marks an unknown display.
    localparam logic [2:0] OM_CPOS  = 3'd0;
    localparam logic [2:0] OM_CVEL  = 3'd1;
    localparam logic [2:0] OM_CTRQ  = 3'd2;
    localparam logic [2:0] OM_PPOS  = 3'd3;
    localparam logic [2:0] OM_HOME  = 3'd4;
    localparam logic [2:0] OM_STILL = 3'd5;
    localparam logic [2:0] OM_NONE  = 3'd7;

    // Mode codes on the drive side.
    localparam logic [7:0] MODE_PP   = 8'd1;
    localparam logic [7:0] MODE_HOME = 8'd6;
    localparam logic [7:0] MODE_CSP  = 8'd8;
    localparam logic [7:0] MODE_CSV  = 8'd9;
    localparam logic [7:0] MODE_CST  = 8'd10;

    // Control words.
    localparam logic [7:0] CW_FAULT_RESET = 8'h80;
    localparam logic [7:0] CW_PTP_START   = 8'h3F;
    localparam logic [7:0] CW_PTP_REARM   = 8'h2F;
    localparam logic [7:0] CW_HOMING      = 8'h1F;
    localparam logic [7:0] CW_RUN         = 8'h0F;
    localparam logic [7:0] CW_ENABLE      = 8'h07;
    localparam logic [7:0] CW_STOP        = 8'h06;
    localparam logic [7:0] CW_OFF         = 8'h00;

    localparam logic signed [15:0] CST_MAX_TORQUE = 16'sd30000;

    // Status word bits.
    localparam int SW_ACK_BIT    = 12;
    localparam int SW_REACHED_BIT = 10;

    typedef struct packed {
        logic [1:0]         command;
        logic [2:0]         op_mode;
        logic [15:0]        status_word;
        logic [7:0]         mode_display;
        logic signed [31:0] actual_position;
        logic signed [31:0] target_position;
        logic signed [15:0] max_torque_in;
        logic               ptp_request;
    } sdcs_in_t;

    typedef struct packed {
        logic [7:0]         control_word;
        logic [7:0]         mode_of_operation;
        logic signed [31:0] target_position_out;
        logic signed [15:0] max_torque_out;
        logic               cmd_complete;
        logic               fault;
        logic [2:0]         drive_state;
    } sdcs_out_t;

endpackage

[rtl/servo_drive_command_sequencer_unit.sv]
// Servo drive command sequencer.
// Input channel (s_valid/s_ready/s_data): one transfer per ready bus cycle carrying the
// wanted command and operation mode together with the drive's status word, mode
// display and actual position. Result channel (m_valid/m_ready/m_data): one
// transfer per input, carrying control word, mode of operation, target position,
// max torque, command-complete, fault and decoded drive state.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes the home offset;
// it is always ready and should be written only while no transfer is in flight.
// The input register takes the item at the transfer and the decode logic then loads
// the result register from it. Throughput is one item per cycle while the receiver
// does not stall, set by the single decode stage between the two registers.
// When the receiver stalls the result register holds, the input register fills,
// and s_ready drops until the result is taken.
// Synchronous active-low reset clears both valid flags, the home offset, the
// pending PTP request, the standstill capture and the last sent mode code.
module servo_drive_command_sequencer_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sdcs_pkg::sdcs_in_t      s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sdcs_pkg::sdcs_out_t     m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic signed [31:0]      cfg_data
);
    import sdcs_pkg::*;

    logic               in_valid_reg;
    sdcs_in_t           in_data_reg;
    logic               out_valid_reg;
    sdcs_out_t          out_data_reg;
    logic signed [31:0] home_offset_reg;
    logic               ptp_pending_reg;
    logic               ptp_pending_next;
    logic               still_captured_reg;
    logic               still_captured_next;
    logic signed [31:0] still_pos_reg;
    logic signed [31:0] still_pos_next;
    logic [7:0]         last_mode_reg;
    sdcs_out_t          out_data_next;
    logic               advance;

    logic [2:0]         st;
    logic [2:0]         cur;
    logic               state_ok;
    logic               ptp_set;
    logic               sw_ack;
    logic               sw_reached;

    // The decode stage moves when it holds an item and the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Control state and configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            home_offset_reg    <= '0;
            ptp_pending_reg    <= 1'b0;
            still_captured_reg <= 1'b0;
            still_pos_reg      <= '0;
            last_mode_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg      <= 1'b1;
                ptp_pending_reg    <= ptp_pending_next;
                still_captured_reg <= still_captured_next;
                still_pos_reg      <= still_pos_next;
                last_mode_reg      <= out_data_next.mode_of_operation;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                home_offset_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Status word and mode display decode.
    always_comb begin
        unique case (in_data_reg.status_word[3:0])
            4'h0:    st = ST_OFF;
            4'h1:    st = ST_STOPPED;
            4'h3:    st = ST_ENABLED;
            4'h7:    st = ST_RUNNING;
            default: st = ST_FAULT;
        endcase
        unique case (in_data_reg.mode_display)
            MODE_PP:   cur = OM_PPOS;
            MODE_HOME: cur = OM_HOME;
            MODE_CSP:  cur = OM_CPOS;
            MODE_CSV:  cur = OM_CVEL;
            MODE_CST:  cur = OM_CTRQ;
            default:   cur = OM_NONE;
        endcase
    end

    assign sw_ack     = in_data_reg.status_word[SW_ACK_BIT];
    assign sw_reached = in_data_reg.status_word[SW_REACHED_BIT];
    assign ptp_set    = ptp_pending_reg || in_data_reg.ptp_request;

    // Control word, mode, setpoints and completion for the item in the input register.
    always_comb begin
        out_data_next.control_word        = CW_FAULT_RESET;
        out_data_next.mode_of_operation   = last_mode_reg;
        out_data_next.target_position_out = in_data_reg.target_position;
        out_data_next.max_torque_out      = in_data_reg.max_torque_in;
        out_data_next.cmd_complete        = 1'b0;
        out_data_next.fault               = (st == ST_FAULT);
        out_data_next.drive_state         = st;
        ptp_pending_next                  = ptp_set;
        still_captured_next               = still_captured_reg;
        still_pos_next                    = still_pos_reg;
        state_ok                          = 1'b0;

        if (st != ST_FAULT) begin
            // Step the drive toward the wanted state.
            unique case (in_data_reg.command)
                REQ_OFF: begin
                    out_data_next.control_word = CW_OFF;
                    state_ok = (st == ST_OFF);
                end
                REQ_STOP: begin
                    out_data_next.control_word = CW_STOP;
                    state_ok = (st == ST_STOPPED);
                end
                REQ_ENABLE: begin
                    out_data_next.control_word = (st == ST_OFF) ? CW_STOP : CW_ENABLE;
                    state_ok = (st == ST_ENABLED);
                end
                default: begin
                    if (st == ST_OFF) begin
                        out_data_next.control_word = CW_STOP;
                    end else if (st == ST_STOPPED) begin
                        out_data_next.control_word = CW_ENABLE;
                    end else begin
                        out_data_next.control_word = CW_RUN;
                    end
                    state_ok = (st == ST_RUNNING);
                end
            endcase

            // Mode-specific setpoints; every defined mode but standstill drops the capture, unknown codes keep it.
            case (in_data_reg.op_mode)
                OM_CPOS: begin
                    out_data_next.mode_of_operation = MODE_CSP;
                    out_data_next.target_position_out =
                        in_data_reg.target_position + home_offset_reg;
                    still_captured_next = 1'b0;
                end
                OM_CVEL: begin
                    out_data_next.mode_of_operation = MODE_CSV;
                    still_captured_next = 1'b0;
                end
                OM_CTRQ: begin
                    out_data_next.mode_of_operation = MODE_CST;
                    out_data_next.max_torque_out = CST_MAX_TORQUE;
                    still_captured_next = 1'b0;
                end
                OM_PPOS: begin
                    out_data_next.mode_of_operation = MODE_PP;
                    if (ptp_set && st == ST_RUNNING && cur == OM_PPOS) begin
                        if (!sw_ack) begin
                            out_data_next.control_word = CW_PTP_START;
                        end else if (!sw_reached) begin
                            ptp_pending_next = 1'b0;
                        end else begin
                            out_data_next.control_word = CW_PTP_REARM;
                        end
                    end
                    still_captured_next = 1'b0;
                end
                OM_HOME: begin
                    out_data_next.mode_of_operation = MODE_HOME;
                    if (st == ST_RUNNING && cur == OM_HOME) begin
                        out_data_next.control_word = CW_HOMING;
                    end
                    still_captured_next = 1'b0;
                end
                OM_STILL: begin
                    out_data_next.mode_of_operation = MODE_CSP;
                    if (!still_captured_reg) begin
                        still_pos_next = in_data_reg.actual_position;
                        still_captured_next = 1'b1;
                    end
                    out_data_next.target_position_out = still_pos_next;
                end
                default: begin
                end
            endcase

            // Complete once state and mode match and the mode's sub-goal is met.
            if (state_ok && in_data_reg.op_mode <= OM_STILL &&
                (cur == in_data_reg.op_mode ||
                 (in_data_reg.op_mode == OM_STILL && cur == OM_CPOS))) begin
                out_data_next.cmd_complete = 1'b1;
                if (cur == OM_HOME && !sw_ack) begin
                    out_data_next.cmd_complete = 1'b0;
                end
                if (cur == OM_PPOS && !sw_reached) begin
                    out_data_next.cmd_complete = 1'b0;
                end
            end
        end
    end

endmodule

[rtl/sdcs_checker.sv]
module sdcs_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input sdcs_pkg::sdcs_out_t  m_data
);
    import sdcs_pkg::*;

    // Reset empties the result side on the next cycle.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Fault flag and fault state agree.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fault == (m_data.drive_state == ST_FAULT)))
        else $error("fault flag does not match drive state");

    // A fault sends the fault reset word and never reports completion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.fault |->
            m_data.control_word == CW_FAULT_RESET && !m_data.cmd_complete)
        else $error("fault result has wrong control word or completion");

    // Only known drive mode codes, or the reset value zero, are sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.mode_of_operation == 8'd0 ||
                     m_data.mode_of_operation == MODE_PP ||
                     m_data.mode_of_operation == MODE_HOME ||
                     m_data.mode_of_operation == MODE_CSP ||
                     m_data.mode_of_operation == MODE_CSV ||
                     m_data.mode_of_operation == MODE_CST))
        else $error("unexpected mode of operation code");

endmodule

bind servo_drive_command_sequencer_unit sdcs_checker u_sdcs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
